@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled in reset.
`define CHK_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

@@ rtl/cbss_pkg.sv @@
package cbss_pkg;
   localparam int MaxSegment = 4096;
   localparam int HexDigits  = 8;
   localparam int SegW       = 13;
   localparam int CsrIdxW    = 1;
   localparam int CsrDataW   = 13;

   localparam logic [CsrIdxW-1:0] CSR_SEPARATOR = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_LEN   = 1'd1;

   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_PAD = 8'h3d;

   typedef enum logic [2:0] {
      PH_HEADER, PH_HDR_LF, PH_DATA, PH_TRL_CR, PH_TRL_LF, PH_DONE
   } phase_type;

   // Work handed from front to back: up to three decoded bytes and a flush.
   typedef struct packed {
      logic [1:0]  nbytes;
      logic [23:0] bits;
      logic        flush;
      logic        frm;
   } job_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        kind;
      logic        last;
      logic [15:0] segments_done;
      logic        overflow_split;
      logic        framing_error;
   } rsp_type;

   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= "A" && c <= "Z") v = {1'b0, 6'(c - 8'd65)};
      else if (c >= "a" && c <= "z") v = {1'b0, 6'(c - 8'd71)};
      else if (c >= "0" && c <= "9") v = {1'b0, 6'(c + 8'd4)};
      else if (c == "+") v = 7'd62;
      else if (c == "/") v = 7'd63;
      return v;
   endfunction

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= "0" && c <= "9") v = {1'b0, 4'(c - 8'd48)};
      else if (c >= "a" && c <= "f") v = {1'b0, 4'(c - 8'd87)};
      else if (c >= "A" && c <= "F") v = {1'b0, 4'(c - 8'd55)};
      return v;
   endfunction
endpackage

@@ rtl/cbss_stream_if.sv @@
interface cbss_stream_if #(parameter int W = 9);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/cbss_front.sv @@
module cbss_front #(
   parameter int HEX_DIGITS = cbss_pkg::HexDigits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        rx_byte,
   input  logic              stream_end,
   input  logic              job_ready,
   output logic              in_ready,
   output logic              job_valid,
   output cbss_pkg::job_type job
);
   import cbss_pkg::*;
   localparam int HcW = $clog2(HEX_DIGITS + 1);

   phase_type   phase_ff, phase_in;
   logic [31:0] len_ff, len_in, rem_ff, rem_in;
   logic [HcW-1:0] hc_ff, hc_in;
   logic [23:0] qb_ff, qb_in;
   logic [2:0]  qf_ff, qf_in;
   logic [1:0]  pad_ff, pad_in;
   logic        frm_ff, frm_in;
   logic        fire, fin;
   logic [6:0]  bv;
   logic [4:0]  hv;
   logic [23:0] qb_n, sh;
   logic [2:0]  qf_n, pads;
   logic [1:0]  pad_n;

   assign in_ready = job_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      phase_in = phase_ff; len_in = len_ff; rem_in = rem_ff; hc_in = hc_ff;
      qb_in = qb_ff; qf_in = qf_ff; pad_in = pad_ff; frm_in = frm_ff;
      job_valid = 1'b0; job = '0; fin = 1'b0;
      bv = b64_value(rx_byte); hv = hex_value(rx_byte);
      qb_n = qb_ff; qf_n = qf_ff; pad_n = pad_ff; sh = '0; pads = '0;
      if (fire && phase_ff != PH_DONE) begin
         if (stream_end) fin = 1'b1;
         else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (rx_byte == CH_CR) phase_in = PH_HDR_LF;
                  else if (!hv[4] && hc_ff < HcW'(HEX_DIGITS)) begin
                     len_in = {len_ff[27:0], hv[3:0]};
                     hc_in = hc_ff + 1'b1;
                  end
               end
               PH_HDR_LF: begin
                  if (rx_byte != CH_LF) frm_in = 1'b1;
                  if (len_ff == 32'd0) fin = 1'b1;
                  else begin
                     rem_in = len_ff; phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (rx_byte == CH_PAD || !bv[6]) begin
                     if (rx_byte == CH_PAD && pad_ff != 2'd3) pad_n = pad_ff + 1'b1;
                     qb_n = {qb_ff[17:0], (rx_byte == CH_PAD) ? 6'd0 : bv[5:0]};
                     qf_n = qf_ff + 1'b1;
                     if (qf_n == 3'd4) begin
                        job_valid = 1'b1;
                        job.bits = qb_n;
                        job.nbytes = 2'(3 - {1'b0, pad_n});
                        qb_n = '0; qf_n = '0; pad_n = '0;
                     end
                  end
                  qb_in = qb_n; qf_in = qf_n; pad_in = pad_n;
                  if (rem_ff != 32'd0) rem_in = rem_ff - 1'b1;
                  if (rem_in == 32'd0) phase_in = PH_TRL_CR;
               end
               PH_TRL_CR: begin
                  if (rx_byte != CH_CR) frm_in = 1'b1;
                  phase_in = PH_TRL_LF;
               end
               PH_TRL_LF: begin
                  if (rx_byte != CH_LF) frm_in = 1'b1;
                  phase_in = PH_HEADER; len_in = '0; hc_in = '0;
               end
               default: ;
            endcase
         end
         if (fin) begin
            job_valid = 1'b1; job.flush = 1'b1;
            if (qf_ff != 3'd0) begin
               case (qf_ff)
                  3'd1: sh = {qb_ff[5:0], 18'd0};
                  3'd2: sh = {qb_ff[11:0], 12'd0};
                  default: sh = {qb_ff[17:0], 6'd0};
               endcase
               pads = {1'b0, pad_ff} + (3'd4 - qf_ff);
               job.bits = sh;
               job.nbytes = (pads >= 3'd3) ? 2'd0 : 2'(3'd3 - pads);
            end
            qb_in = '0; qf_in = '0; pad_in = '0; phase_in = PH_DONE;
         end
         // a fire item with no job still needs no output; frm is sampled by back
      end
      job.frm = frm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; len_ff <= '0; rem_ff <= '0; hc_ff <= '0;
         qb_ff <= '0; qf_ff <= '0; pad_ff <= '0; frm_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; len_ff <= len_in; rem_ff <= rem_in; hc_ff <= hc_in;
         qb_ff <= qb_in; qf_ff <= qf_in; pad_ff <= pad_in; frm_ff <= frm_in;
      end
   end
endmodule

@@ rtl/cbss_queue.sv @@
module cbss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  cbss_pkg::job_type wr_data,
   output logic              wr_ready,
   output logic              rd_valid,
   output cbss_pkg::job_type rd_data,
   input  logic              rd_ready
);
   import cbss_pkg::*;
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= ~wp_ff;
         if (rd_valid && rd_ready) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
   end
endmodule

@@ rtl/cbss_back.sv @@
module cbss_back #(
   parameter int MAX_SEGMENT = cbss_pkg::MaxSegment
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        sep,
   input  logic [12:0]       max_len,
   input  logic              job_valid,
   input  cbss_pkg::job_type job,
   output logic              job_ready,
   output logic              out_valid,
   output cbss_pkg::rsp_type out_data,
   input  logic              out_ready
);
   import cbss_pkg::*;
   localparam int LW = $clog2(MAX_SEGMENT + 1);

   // One step per cycle if not stalled: data byte, separator, limit or flush close.
   logic [1:0]    idx_ff, idx_in;
   logic          pend_ff, pend_in;   // limit close emitted, byte still owed
   logic [LW-1:0] slen_ff, slen_in;
   logic [15:0]   segs_ff, segs_in;
   logic          ov_ff, ov_in;
   rsp_type       ob_ff, ob_in;
   logic [7:0]    b;
   logic [LW:0]   lim;
   logic          emit, done_job, more;
   logic          rest_sep, later;
   rsp_type       r;

   assign out_valid = ov_ff;
   assign out_data  = ob_ff;

   always_comb begin
      lim = (max_len == 13'd0) ? (LW+1)'(1) : (LW+1)'(max_len);
      if (max_len > 13'(MAX_SEGMENT) && MAX_SEGMENT < 8192) lim = (LW+1)'(MAX_SEGMENT);
      case (idx_ff)
         2'd0: b = job.bits[23:16];
         2'd1: b = job.bits[15:8];
         default: b = job.bits[7:0];
      endcase
      idx_in = idx_ff; pend_in = pend_ff; slen_in = slen_ff; segs_in = segs_ff;
      emit = 1'b0; done_job = 1'b0; r = '0; r.framing_error = job.frm;
      more = 1'b0; rest_sep = 1'b1; later = 1'b0;
      if (job_valid && (!ov_ff || out_ready)) begin
         if ({1'b0, idx_ff} < {1'b0, job.nbytes}) begin
            more = 1'b1;
            if (b == sep && !pend_ff) begin
               if (slen_ff != '0) begin
                  emit = 1'b1; r.kind = 1'b1; slen_in = '0;
                  if (segs_ff != 16'hffff) segs_in = segs_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else if ((LW+1)'(slen_ff) >= lim && !pend_ff) begin
               emit = 1'b1; r.kind = 1'b1; r.overflow_split = 1'b1;
               slen_in = '0; pend_in = 1'b1;
               if (segs_ff != 16'hffff) segs_in = segs_ff + 1'b1;
            end else begin
               emit = 1'b1; r.out_byte = b; slen_in = slen_ff + 1'b1;
               pend_in = 1'b0; idx_in = idx_ff + 1'b1;
            end
         end else begin
            if (job.flush && slen_ff != '0) begin
               emit = 1'b1; r.kind = 1'b1; slen_in = '0;
               if (segs_ff != 16'hffff) segs_in = segs_ff + 1'b1;
            end
            done_job = 1'b1;
         end
         if (more && {1'b0, idx_in} >= {1'b0, job.nbytes} && !job.flush) done_job = 1'b1;
         // last: no later step of this job gives a transfer; separators left over
         // an empty segment give nothing
         for (int j = 0; j < 3; j++)
            if (2'(j) >= idx_in && 2'(j) < job.nbytes && job.bits[23-8*j -: 8] != sep)
               rest_sep = 1'b0;
         if ({1'b0, idx_in} < {1'b0, job.nbytes}) later = !(slen_in == '0 && rest_sep);
         else later = job.flush && slen_in != '0;
         r.last = !later;
      end
      r.segments_done = segs_in;
      job_ready = done_job;
      if (done_job) idx_in = '0;
      ov_in = ov_ff && !out_ready;
      ob_in = ob_ff;
      if (emit) begin
         ov_in = 1'b1; ob_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; pend_ff <= 1'b0; slen_ff <= '0; segs_ff <= '0; ov_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in; pend_ff <= pend_in; slen_ff <= slen_in;
         segs_ff <= segs_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) ob_ff <= ob_in;
endmodule

@@ rtl/chunked_base64_segment_splitter.sv @@
// Channel | Dir | Payload
// req     | in  | {stream_end, rx_byte}, 9 bits
// rsp     | out | {out_byte, kind, last, segments_done, overflow_split, framing_error}, 28 bits
// csr     | in  | csr_we, csr_index, csr_wdata
// The front parser takes one input byte per cycle while the job queue has room.
// The back splitter takes one step per decoded byte, one more per limit split and
// one for a flush close.
// A result passes from its input transfer through the job queue to the output register.
// Synchronous active-high reset clears all control state; no clearing pass.
// A two-entry job queue between front and back lets each side stall alone.
module chunked_base64_segment_splitter #(
   parameter int MAX_SEGMENT = cbss_pkg::MaxSegment,
   parameter int HEX_DIGITS  = cbss_pkg::HexDigits
) (
   input  logic                            clock,
   input  logic                            reset,
   cbss_stream_if.sink                     req,
   cbss_stream_if.source                   rsp,
   input  logic                            csr_we,
   input  logic [cbss_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [cbss_pkg::CsrDataW-1:0]   csr_wdata
);
   import cbss_pkg::*;

   logic [7:0]  sep_ff;
   logic [12:0] maxl_ff;
   logic        fj_valid, fj_ready, bj_valid, bj_ready;
   job_type     fj, bj;
   rsp_type     r;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= 8'd10; maxl_ff <= 13'd4096;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEPARATOR: sep_ff <= csr_wdata[7:0];
            CSR_MAX_LEN:   maxl_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   cbss_front #(.HEX_DIGITS(HEX_DIGITS)) u_front (
      .clock, .reset, .in_valid(req.valid), .rx_byte(req.payload[7:0]),
      .stream_end(req.payload[8]), .job_ready(fj_ready), .in_ready(req.ready),
      .job_valid(fj_valid), .job(fj)
   );

   cbss_queue u_queue (
      .clock, .reset, .wr_valid(fj_valid), .wr_data(fj), .wr_ready(fj_ready),
      .rd_valid(bj_valid), .rd_data(bj), .rd_ready(bj_ready)
   );

   cbss_back #(.MAX_SEGMENT(MAX_SEGMENT)) u_back (
      .clock, .reset, .sep(sep_ff), .max_len(maxl_ff), .job_valid(bj_valid),
      .job(bj), .job_ready(bj_ready), .out_valid(rsp.valid), .out_data(r),
      .out_ready(rsp.ready)
   );

   assign rsp.payload = r;
endmodule

@@ rtl/cbss_checker.sv @@
`include "assert_macros.svh"
module cbss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_payload
);
   logic stall, mark, ovf;

   assign stall = rsp_valid && !rsp_ready;
   assign mark  = rsp_valid && rsp_payload[19];
   assign ovf   = rsp_valid && rsp_payload[1];

   `CHK_NEXT(a_hold, clock, reset, stall, rsp_valid && $stable(rsp_payload), "rsp stall")
   `CHK_IMPL(a_mark_zero, clock, reset, mark, rsp_payload[27:20] == 8'd0, "marker byte")
   `CHK_IMPL(a_ovf_kind, clock, reset, ovf, rsp_payload[19], "ovf on data")
endmodule

bind chunked_base64_segment_splitter cbss_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
